@@ rtl/core/hbrp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP byte-range parser package
// Shared widths, character codes, verdict codes, the per-value range record
// and the decimal accumulate step.
// ----------------------------------------------------------------------------
package hbrp_pkg;

  // Width of the digit accumulators; values beyond it overflow.
  localparam int POS_BITS = 48;
  // Width of the content length and of the result positions.
  localparam int LEN_BITS = 48;
  localparam int OUT_BITS = 48;
  // Width that holds both an accumulator and a length for comparisons.
  localparam int CMP_W = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;

  // Characters of interest in a header value.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Length of the "bytes=" unit prefix.
  localparam logic [2:0] PREFIX_LEN = 3'd6;

  // Result verdicts.
  typedef enum logic [1:0] {
    VERDICT_SAT       = 2'd0,
    VERDICT_UNSAT     = 2'd1,
    VERDICT_NOT_RANGE = 2'd2
  } verdict_e;

  // Everything the decision stage needs about one finished header value.
  typedef struct packed {
    logic                not_bytes;
    logic                syntax_bad;
    logic                overflow;
    logic                end_open;
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS-1:0] end_pos;
    logic [LEN_BITS-1:0] length;
  } range_rec_t;

  // Lower-case characters of the "bytes=" prefix, by position.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;  // b
      3'd1:    ch = 8'h79;  // y
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h73;  // s
      3'd5:    ch = 8'h3d;  // =
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // One decimal step acc*10 + digit. The top bit of the result flags an
  // overflow, in which case the value saturates to all ones.
  function automatic logic [POS_BITS:0] acc_digit(input logic [POS_BITS-1:0] acc,
                                                  input logic [7:0]          ch);
    logic [3:0]          digit;
    logic [POS_BITS+3:0] sum;
    digit = 4'(ch - CH_ZERO);
    sum   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{POS_BITS{1'b0}}, digit};
    if (|sum[POS_BITS+3:POS_BITS]) begin
      return {1'b1, {POS_BITS{1'b1}}};
    end
    return {1'b0, sum[POS_BITS-1:0]};
  endfunction

endpackage

@@ rtl/core/http_byte_range_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP byte-range parser
// Parses a Range header value such as "bytes=100-199" one byte at a time and
// gives one verdict per value against the resource's content length.
// ----------------------------------------------------------------------------
// The block accepts one header byte per clock cycle while in_ready_o is high;
// values follow each other directly. Each byte is registered, then the parse
// state advances by one byte through a single times-ten accumulate unit. A NUL
// byte ends the parse early and the bytes after it are ignored, but only the
// byte flagged by final_byte_i hands a range record to the decision stage.
// The final byte passes the input register and the record register; the result
// register then holds the result until out_ready_i takes it; while it waits,
// the block keeps accepting bytes of the next value, and stalls the input only
// when a further final byte finds both internal slots full.
// ----------------------------------------------------------------------------
module http_byte_range_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    header_byte_i,
  input  logic                          final_byte_i,
  input  logic [hbrp_pkg::LEN_BITS-1:0] content_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    verdict_o,
  output logic [hbrp_pkg::OUT_BITS-1:0] first_pos_o,
  output logic [hbrp_pkg::OUT_BITS-1:0] last_pos_o
);

  logic                 rec_valid;
  logic                 rec_ready;
  hbrp_pkg::range_rec_t rec;

  // Byte scanner.
  hbrp_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .header_byte_i    (header_byte_i),
    .final_byte_i     (final_byte_i),
    .content_length_i (content_length_i),
    .rec_valid_o      (rec_valid),
    .rec_ready_i      (rec_ready),
    .rec_o            (rec)
  );

  // Range decision and result register.
  hbrp_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .rec_i       (rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o),
    .first_pos_o (first_pos_o),
    .last_pos_o  (last_pos_o)
  );

endmodule

@@ rtl/core/hbrp_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP byte-range parser: byte scanner
// Registers each incoming byte, advances the parse state by one byte per
// cycle unless a last byte meets a full record slot and, on the last byte of a value, hands a range record downstream.
// ----------------------------------------------------------------------------
module hbrp_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                header_byte_i,
  input  logic                      final_byte_i,
  input  logic [hbrp_pkg::LEN_BITS-1:0] content_length_i,
  output logic                      rec_valid_o,
  input  logic                      rec_ready_i,
  output hbrp_pkg::range_rec_t      rec_o
);

  // Parse phases.
  localparam logic [2:0] PH_PREFIX   = 3'd0;
  localparam logic [2:0] PH_NOTBYTES = 3'd1;
  localparam logic [2:0] PH_LEAD     = 3'd2;
  localparam logic [2:0] PH_START    = 3'd3;
  localparam logic [2:0] PH_GAP      = 3'd4;
  localparam logic [2:0] PH_DASH     = 3'd5;
  localparam logic [2:0] PH_END      = 3'd6;
  localparam logic [2:0] PH_DONE     = 3'd7;

  localparam int PB = hbrp_pkg::POS_BITS;

  // Input register.
  logic                          in_valid_q;
  logic [7:0]                    byte_q;
  logic                          fin_q;
  logic [hbrp_pkg::LEN_BITS-1:0] len_q;

  // Parse state.
  logic [2:0]    phase_q, phase_d;
  logic [2:0]    idx_q, idx_d;
  logic [PB-1:0] start_q, start_d;
  logic [PB-1:0] end_q, end_d;
  logic          open_q, open_d;
  logic          bad_q, bad_d;
  logic          ovf_q, ovf_d;

  // Record register.
  logic                 rec_valid_q;
  hbrp_pkg::range_rec_t rec_q, rec_d;

  logic          rec_free;
  logic          step;
  logic          active;
  logic          is_digit;
  logic [7:0]    lower_ch;
  logic [PB-1:0] acc_src;
  logic [PB:0]   acc_res;

  // A byte is consumed unless it ends a value while the record slot is full.
  assign rec_free   = !rec_valid_q || rec_ready_i;
  assign step       = in_valid_q && (!fin_q || rec_free);
  assign in_ready_o = !in_valid_q || step;

  // Shared decimal accumulate unit, fed by the accumulator of the phase.
  assign acc_src = (phase_q == PH_DASH || phase_q == PH_END) ? end_q : start_q;
  assign acc_res = hbrp_pkg::acc_digit(acc_src, byte_q);

  assign is_digit = (byte_q >= hbrp_pkg::CH_ZERO) && (byte_q <= hbrp_pkg::CH_NINE);
  assign lower_ch = (byte_q >= hbrp_pkg::CH_UPPER_A && byte_q <= hbrp_pkg::CH_UPPER_Z) ?
                    byte_q + hbrp_pkg::CASE_DELTA : byte_q;
  assign active   = (phase_q != PH_DONE) && (phase_q != PH_NOTBYTES);

  // Next parse state for the registered byte.
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    start_d = start_q;
    end_d   = end_q;
    open_d  = open_q;
    bad_d   = bad_q;
    ovf_d   = ovf_q;

    // Take a non-NUL byte.
    if (active && byte_q != hbrp_pkg::CH_NUL) begin
      case (phase_q)
        PH_PREFIX: begin
          if (idx_q < hbrp_pkg::PREFIX_LEN && lower_ch == hbrp_pkg::prefix_char(idx_q)) begin
            idx_d = idx_q + 3'd1;
            if (idx_q + 3'd1 == hbrp_pkg::PREFIX_LEN) begin
              phase_d = PH_LEAD;
            end
          end else begin
            phase_d = PH_NOTBYTES;
          end
        end
        PH_LEAD: begin
          if (byte_q == hbrp_pkg::CH_SPACE) begin
            phase_d = PH_LEAD;
          end else if (is_digit) begin
            start_d = acc_res[PB-1:0];
            ovf_d   = ovf_q | acc_res[PB];
            phase_d = PH_START;
          end else begin
            bad_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_START: begin
          if (is_digit) begin
            start_d = acc_res[PB-1:0];
            ovf_d   = ovf_q | acc_res[PB];
          end else if (byte_q == hbrp_pkg::CH_SPACE) begin
            phase_d = PH_GAP;
          end else if (byte_q == hbrp_pkg::CH_DASH) begin
            phase_d = PH_DASH;
          end else begin
            bad_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_GAP: begin
          if (byte_q == hbrp_pkg::CH_SPACE) begin
            phase_d = PH_GAP;
          end else if (byte_q == hbrp_pkg::CH_DASH) begin
            phase_d = PH_DASH;
          end else begin
            bad_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_DASH: begin
          if (byte_q == hbrp_pkg::CH_SPACE) begin
            phase_d = PH_DASH;
          end else if (is_digit) begin
            end_d   = acc_res[PB-1:0];
            ovf_d   = ovf_q | acc_res[PB];
            phase_d = PH_END;
          end else begin
            bad_d   = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_END: begin
          if (is_digit) begin
            end_d = acc_res[PB-1:0];
            ovf_d = ovf_q | acc_res[PB];
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    // A NUL byte or the last byte closes the value.
    if (active && (byte_q == hbrp_pkg::CH_NUL || fin_q)) begin
      case (phase_d)
        PH_PREFIX: begin
          phase_d = PH_NOTBYTES;
        end
        PH_LEAD, PH_START, PH_GAP: begin
          bad_d   = 1'b1;
          phase_d = PH_DONE;
        end
        PH_DASH: begin
          open_d  = 1'b1;
          phase_d = PH_DONE;
        end
        PH_END: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = phase_d;
        end
      endcase
    end

    rec_d.not_bytes  = (phase_d == PH_NOTBYTES);
    rec_d.syntax_bad = bad_d;
    rec_d.overflow   = ovf_d;
    rec_d.end_open   = open_d;
    rec_d.start_pos  = start_d;
    rec_d.end_pos    = end_d;
    rec_d.length     = len_q;
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= header_byte_i;
      fin_q  <= final_byte_i;
      len_q  <= content_length_i;
    end
  end

  // Parse state: cleared after the last byte of each value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      idx_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      open_q  <= 1'b0;
      bad_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (step) begin
      if (fin_q) begin
        phase_q <= PH_PREFIX;
        idx_q   <= '0;
        start_q <= '0;
        end_q   <= '0;
        open_q  <= 1'b0;
        bad_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        start_q <= start_d;
        end_q   <= end_d;
        open_q  <= open_d;
        bad_q   <= bad_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // Record register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
    end else begin
      rec_valid_q <= (rec_valid_q && !rec_ready_i) || (step && fin_q);
    end
  end

  // Record register payload.
  always_ff @(posedge clk_i) begin
    if (step && fin_q) begin
      rec_q <= rec_d;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

@@ rtl/core/hbrp_decide.sv @@
// ----------------------------------------------------------------------------
// HTTP byte-range parser: range decision
// Weighs a finished range record against the content length and holds the
// verdict and positions in the result register.
// ----------------------------------------------------------------------------
module hbrp_decide (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  output logic                          rec_ready_o,
  input  hbrp_pkg::range_rec_t          rec_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    verdict_o,
  output logic [hbrp_pkg::OUT_BITS-1:0] first_pos_o,
  output logic [hbrp_pkg::OUT_BITS-1:0] last_pos_o
);

  localparam int CW = hbrp_pkg::CMP_W;

  logic          out_valid_q;
  logic [1:0]    verdict_q;
  logic [hbrp_pkg::OUT_BITS-1:0] first_q, last_q;

  logic [CW-1:0] start_x, end_x, len_x, lenm1_x, end_sel;
  logic          len_nz;
  logic          end_ge_len;
  logic          use_lenm1;
  logic          start_gt_end;
  logic          start_gt_len;
  logic          ok;
  hbrp_pkg::verdict_e verdict_d;

  assign rec_ready_o = !out_valid_q || out_ready_i;

  assign start_x = CW'(rec_i.start_pos);
  assign end_x   = CW'(rec_i.end_pos);
  assign len_x   = CW'(rec_i.length);
  assign lenm1_x = len_x - CW'(1);
  assign len_nz  = (rec_i.length != '0);

  // The compares run side by side; the clamp only selects among them.
  assign end_ge_len   = (end_x >= len_x);
  assign start_gt_len = (start_x > len_x);
  assign use_lenm1    = len_nz && (rec_i.end_open || end_ge_len);
  assign end_sel      = use_lenm1 ? lenm1_x : end_x;
  assign start_gt_end = use_lenm1 ? (start_x > lenm1_x) : (start_x > end_x);

  // An open end with an empty resource cannot be served.
  assign ok = !rec_i.syntax_bad && !rec_i.overflow && !(rec_i.end_open && !len_nz) &&
              !start_gt_end && !start_gt_len;

  always_comb begin
    if (rec_i.not_bytes) begin
      verdict_d = hbrp_pkg::VERDICT_NOT_RANGE;
    end else if (ok) begin
      verdict_d = hbrp_pkg::VERDICT_SAT;
    end else begin
      verdict_d = hbrp_pkg::VERDICT_UNSAT;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_ready_o) begin
      out_valid_q <= rec_valid_i;
    end
  end

  // Result register payload; positions are zero unless the range is served.
  always_ff @(posedge clk_i) begin
    if (rec_ready_o && rec_valid_i) begin
      verdict_q <= verdict_d;
      if (verdict_d == hbrp_pkg::VERDICT_SAT) begin
        first_q <= start_x[hbrp_pkg::OUT_BITS-1:0];
        last_q  <= end_sel[hbrp_pkg::OUT_BITS-1:0];
      end else begin
        first_q <= '0;
        last_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign first_pos_o = first_q;
  assign last_pos_o  = last_q;

endmodule

@@ rtl/core/hbrp_checker.sv @@
// ----------------------------------------------------------------------------
// HTTP byte-range parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hbrp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    verdict_o,
  input logic [hbrp_pkg::OUT_BITS-1:0] first_pos_o,
  input logic [hbrp_pkg::OUT_BITS-1:0] last_pos_o
);

  // A stalled result keeps its verdict and positions.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) &&
    $stable(first_pos_o) && $stable(last_pos_o))
    else $error("result changed while stalled");

  // Only the three defined verdicts are ever shown.
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o == hbrp_pkg::VERDICT_SAT ||
                    verdict_o == hbrp_pkg::VERDICT_UNSAT ||
                    verdict_o == hbrp_pkg::VERDICT_NOT_RANGE)
    else $error("undefined verdict code");

  // A refused range carries zero positions.
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != hbrp_pkg::VERDICT_SAT |->
    first_pos_o == '0 && last_pos_o == '0)
    else $error("nonzero positions on a refused range");

  // A served range never runs backwards.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == hbrp_pkg::VERDICT_SAT |-> first_pos_o <= last_pos_o)
    else $error("served range starts after its end");

endmodule

bind http_byte_range_parser hbrp_checker u_hbrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .verdict_o   (verdict_o),
  .first_pos_o (first_pos_o),
  .last_pos_o  (last_pos_o)
);
